FILE: rtl/qcpe_pkg.sv
`default_nettype none
package qcpe_pkg;

  // coordinate width default
  localparam int COORD_BITS_DEF = 16;

  // header point count width
  localparam int COUNT_BITS = 16;

  // results one item can cause
  localparam int MAX_RES = 2;

  // item kind codes
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_POINT  = 1'b1;

  // per-result flags handed from the core to the result buffer
  typedef struct packed {
    logic on_curve;
    logic closes;
    logic last;
  } res_flags_t;

endpackage
`default_nettype wire

FILE: rtl/qcpe_core.sv
`default_nettype none
module qcpe_core #(
  parameter int COORD_BITS = qcpe_pkg::COORD_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   commit,
  input  wire                                   kind,
  input  wire signed [COORD_BITS-1:0]           coord_x,
  input  wire signed [COORD_BITS-1:0]           coord_y,
  input  wire                                   is_on_curve,
  input  wire        [qcpe_pkg::COUNT_BITS-1:0] point_count,
  output logic       [1:0]                      res_n,
  output logic signed [COORD_BITS-1:0]          res_x [qcpe_pkg::MAX_RES],
  output logic signed [COORD_BITS-1:0]          res_y [qcpe_pkg::MAX_RES],
  output qcpe_pkg::res_flags_t                  res_flags [qcpe_pkg::MAX_RES]
);

  // contour state
  logic signed [COORD_BITS-1:0]           tail_x_r, tail_y_r, prev_x_r, prev_y_r;
  logic signed [COORD_BITS-1:0]           tail_x_nxt, tail_y_nxt, prev_x_nxt, prev_y_nxt;
  logic                                   tail_on_r, prev_on_r, at_first_r, drop_r;
  logic                                   tail_on_nxt, prev_on_nxt, at_first_nxt, drop_nxt;
  logic [qcpe_pkg::COUNT_BITS-1:0]        left_r, left_nxt;

  logic                                   is_pt, active;
  logic [qcpe_pkg::COUNT_BITS-1:0]        left;
  logic                                   left_zero, left_one;
  logic                                   lead_mid, lead_tail, has_lead;
  logic                                   drop_eff, prev_on_eff, emit_pt, closes_pt, ins_mid;
  logic signed [COORD_BITS-1:0]           mate_x, mate_y, mid_x, mid_y;
  logic signed [COORD_BITS:0]             sum_x, sum_y, adj_x, adj_y;
  logic signed [COORD_BITS-1:0]           s0_x, s0_y;
  qcpe_pkg::res_flags_t                   s0_f, s1_f;
  logic [1:0]                             n;

  // decode of the current point against the contour state
  always_comb begin
    is_pt       = (kind == qcpe_pkg::KIND_POINT);
    active      = is_pt && (left_r != '0);
    left        = left_r - qcpe_pkg::COUNT_BITS'(1);
    left_zero   = (left == '0);
    left_one    = (left == qcpe_pkg::COUNT_BITS'(1));
    lead_mid    = at_first_r && !is_on_curve && !tail_on_r;
    lead_tail   = at_first_r && !is_on_curve && tail_on_r;
    has_lead    = lead_mid || lead_tail;
    drop_eff    = drop_r || lead_tail;
    prev_on_eff = at_first_r ? 1'b1 : prev_on_r;
    emit_pt     = !(drop_eff && left_zero);
    closes_pt   = left_zero || (drop_eff && left_one);
    ins_mid     = emit_pt && !prev_on_eff && !is_on_curve;
  end

  // shared midpoint unit, truncating toward zero
  always_comb begin
    mate_x = at_first_r ? tail_x_r : prev_x_r;
    mate_y = at_first_r ? tail_y_r : prev_y_r;
    sum_x  = {coord_x[COORD_BITS-1], coord_x} + {mate_x[COORD_BITS-1], mate_x};
    sum_y  = {coord_y[COORD_BITS-1], coord_y} + {mate_y[COORD_BITS-1], mate_y};
    adj_x  = sum_x + {{COORD_BITS{1'b0}}, sum_x[COORD_BITS]};
    adj_y  = sum_y + {{COORD_BITS{1'b0}}, sum_y[COORD_BITS]};
    mid_x  = adj_x[COORD_BITS:1];
    mid_y  = adj_y[COORD_BITS:1];
  end

  // result slots: leading or inserted point first, then the point itself
  always_comb begin
    n = 2'd0;
    if (active) begin
      n = {1'b0, has_lead} + {1'b0, ins_mid} + {1'b0, emit_pt};
    end
    s0_f.last = (n == 2'd1);
    if (lead_tail) begin
      s0_x        = tail_x_r;
      s0_y        = tail_y_r;
      s0_f.on_curve = 1'b1;
      s0_f.closes = left_zero;
    end else if (lead_mid || ins_mid) begin
      s0_x        = mid_x;
      s0_y        = mid_y;
      s0_f.on_curve = 1'b1;
      s0_f.closes = 1'b0;
    end else begin
      s0_x        = coord_x;
      s0_y        = coord_y;
      s0_f.on_curve = is_on_curve;
      s0_f.closes = closes_pt;
    end
    s1_f.on_curve = is_on_curve;
    s1_f.closes   = closes_pt;
    s1_f.last     = 1'b1;
    res_n        = n;
    res_x[0]     = s0_x;
    res_y[0]     = s0_y;
    res_flags[0] = s0_f;
    res_x[1]     = coord_x;
    res_y[1]     = coord_y;
    res_flags[1] = s1_f;
  end

  // next contour state
  always_comb begin
    tail_x_nxt   = tail_x_r;
    tail_y_nxt   = tail_y_r;
    tail_on_nxt  = tail_on_r;
    prev_x_nxt   = prev_x_r;
    prev_y_nxt   = prev_y_r;
    prev_on_nxt  = prev_on_r;
    at_first_nxt = at_first_r;
    drop_nxt     = drop_r;
    left_nxt     = left_r;
    if (commit) begin
      if (!is_pt) begin
        tail_x_nxt   = coord_x;
        tail_y_nxt   = coord_y;
        tail_on_nxt  = is_on_curve;
        left_nxt     = point_count;
        drop_nxt     = 1'b0;
        prev_on_nxt  = 1'b1;
        at_first_nxt = 1'b1;
      end else if (active) begin
        left_nxt     = left;
        at_first_nxt = 1'b0;
        drop_nxt     = drop_eff;
        prev_on_nxt  = emit_pt ? is_on_curve : prev_on_eff;
        if (emit_pt) begin
          prev_x_nxt = coord_x;
          prev_y_nxt = coord_y;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_on_r  <= 1'b1;
      prev_on_r  <= 1'b1;
      at_first_r <= 1'b1;
      drop_r     <= 1'b0;
      left_r     <= '0;
    end else begin
      tail_on_r  <= tail_on_nxt;
      prev_on_r  <= prev_on_nxt;
      at_first_r <= at_first_nxt;
      drop_r     <= drop_nxt;
      left_r     <= left_nxt;
    end
  end

  // coordinates
  always_ff @(posedge clk) begin
    tail_x_r <= tail_x_nxt;
    tail_y_r <= tail_y_nxt;
    prev_x_r <= prev_x_nxt;
    prev_y_r <= prev_y_nxt;
  end

`ifndef NO_ASSERTIONS
  // a point never raises the remaining count
  a_left_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && is_pt && left_r != '0) |=> (left_r == $past(left_r) - 1'b1))
    else $error("point count did not step down");

  // two results only ever come from a leading point or an inserted midpoint
  a_two_res: assert property (@(posedge clk) disable iff (!rst_n)
    (res_n == 2'd2) |-> (has_lead || ins_mid))
    else $error("two results without an extra point");

  // the first point of a contour clears the first-point flag
  a_first_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && active) |=> !at_first_r)
    else $error("first-point flag still set");
`endif

endmodule
`default_nettype wire

FILE: rtl/qcpe_obuf.sv
`default_nettype none
module qcpe_obuf #(
  parameter int COORD_BITS = qcpe_pkg::COORD_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          load,
  input  wire  [1:0]                   load_n,
  input  wire  signed [COORD_BITS-1:0] load_x [qcpe_pkg::MAX_RES],
  input  wire  signed [COORD_BITS-1:0] load_y [qcpe_pkg::MAX_RES],
  input  wire  qcpe_pkg::res_flags_t   load_flags [qcpe_pkg::MAX_RES],
  output logic                         can_load,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output qcpe_pkg::res_flags_t         out_flags
);

  logic [1:0]                   cnt_r, cnt_nxt;
  logic signed [COORD_BITS-1:0] x0_r, y0_r, x1_r, y1_r;
  qcpe_pkg::res_flags_t         f0_r, f1_r;
  logic                         pop;

  // drain status
  always_comb begin
    pop       = out_valid && out_ready;
    can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);
    out_valid = (cnt_r != 2'd0);
    out_x     = x0_r;
    out_y     = y0_r;
    out_flags = f0_r;
  end

  // fill count
  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = load_n;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // result slots, head in slot 0
  always_ff @(posedge clk) begin
    if (load) begin
      x0_r <= load_x[0];
      y0_r <= load_y[0];
      f0_r <= load_flags[0];
      x1_r <= load_x[1];
      y1_r <= load_y[1];
      f1_r <= load_flags[1];
    end else if (pop) begin
      x0_r <= x1_r;
      y0_r <= y1_r;
      f0_r <= f1_r;
    end
  end

`ifndef NO_ASSERTIONS
  // count never exceeds the two slots
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer overfilled");

  // a load only lands in a buffer that is empty after this cycle
  a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("load into a busy result buffer");

  // after a load the count is the number of results loaded
  a_load_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (cnt_r == $past(load_n)))
    else $error("result count wrong after load");
`endif

endmodule
`default_nettype wire

FILE: rtl/quadratic_contour_point_expander.sv
// Each item passes the input register, then the result register, which offers
// its results; it waits while the result buffer cannot take it. Throughput:
// one item per cycle while each item causes at most one result and out_ready
// is high; the port delivers one result per cycle, so an item with two results
// holds up the next. Synchronous active-low reset empties both stages.
`default_nettype none
module quadratic_contour_point_expander #(
  parameter int COORD_BITS = qcpe_pkg::COORD_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   in_kind,
  input  wire signed [COORD_BITS-1:0]           in_coord_x,
  input  wire signed [COORD_BITS-1:0]           in_coord_y,
  input  wire                                   in_is_on_curve,
  input  wire        [qcpe_pkg::COUNT_BITS-1:0] in_point_count,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [COORD_BITS-1:0]          out_x,
  output logic signed [COORD_BITS-1:0]          out_y,
  output logic                                  out_on_curve,
  output logic                                  out_closes_contour,
  output logic                                  out_final_of_run
);

  logic                            full_r, full_nxt;
  logic                            kind_r, on_r;
  logic signed [COORD_BITS-1:0]    x_r, y_r;
  logic [qcpe_pkg::COUNT_BITS-1:0] cnt_r;
  logic                            move, can_load, take;
  logic [1:0]                      res_n;
  logic signed [COORD_BITS-1:0]    res_x [qcpe_pkg::MAX_RES];
  logic signed [COORD_BITS-1:0]    res_y [qcpe_pkg::MAX_RES];
  qcpe_pkg::res_flags_t            res_flags [qcpe_pkg::MAX_RES];
  qcpe_pkg::res_flags_t            out_flags;

  // input stage handshake
  always_comb begin
    move     = full_r && ((res_n == 2'd0) || can_load);
    in_ready = !full_r || move;
    take     = in_valid && in_ready;
    full_nxt = take ? 1'b1 : (move ? 1'b0 : full_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (take) begin
      kind_r <= in_kind;
      x_r    <= in_coord_x;
      y_r    <= in_coord_y;
      on_r   <= in_is_on_curve;
      cnt_r  <= in_point_count;
    end
  end

  qcpe_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .commit      (move),
    .kind        (kind_r),
    .coord_x     (x_r),
    .coord_y     (y_r),
    .is_on_curve (on_r),
    .point_count (cnt_r),
    .res_n       (res_n),
    .res_x       (res_x),
    .res_y       (res_y),
    .res_flags   (res_flags)
  );

  qcpe_obuf #(
    .COORD_BITS (COORD_BITS)
  ) u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (move && (res_n != 2'd0)),
    .load_n     (res_n),
    .load_x     (res_x),
    .load_y     (res_y),
    .load_flags (res_flags),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_flags  (out_flags)
  );

  // result flags onto the port
  always_comb begin
    out_on_curve       = out_flags.on_curve;
    out_closes_contour = out_flags.closes;
    out_final_of_run   = out_flags.last;
  end

endmodule
`default_nettype wire
